// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the divider controller and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i64div_pkg.sv -----
// Package with the widths, codes and control types of the 64-bit divider.
`timescale 1ns / 1ps

package i64div_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int FIELD_W    = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam logic REQ_SIGNED   = 1'b0;
    localparam logic REQ_UNSIGNED = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic write_out;
    } dv_cmd_t;

    typedef struct packed {
        logic last;
    } dv_status_t;

endpackage

// ----- rtl/i64div_datapath.sv -----
// Datapath of the divider: operand preparation, restoring shift-subtract loop and result register.
`timescale 1ns / 1ps

module i64div_datapath
    import i64div_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dv_cmd_t    cmd,
    output dv_status_t status,
    input  logic       req_type,
    input  field_t     dividend,
    input  field_t     divisor,
    output field_t     quotient,
    output field_t     remainder,
    output logic       div_by_zero
);

    word_t                 a_in;
    word_t                 b_in;
    logic                  is_signed;
    logic                  a_neg;
    logic                  b_neg;
    word_t                 mag_a;
    word_t                 mag_b;
    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   trial;
    logic                  fits;
    word_t                 q_fix;
    word_t                 r_fix;

    word_t quo_reg;
    word_t rem_reg;
    word_t div_reg;
    logic  q_neg_reg;
    logic  r_neg_reg;
    logic  dbz_reg;
    cnt_t  cnt_reg;

    field_t quotient_reg;
    field_t remainder_reg;
    logic   dbz_out_reg;

    always_comb
    begin
        a_in      = dividend[DATA_WIDTH-1:0];
        b_in      = divisor[DATA_WIDTH-1:0];
        is_signed = (req_type == REQ_SIGNED);
        a_neg     = is_signed & a_in[DATA_WIDTH-1];
        b_neg     = is_signed & b_in[DATA_WIDTH-1];
        mag_a     = a_neg ? (~a_in + word_t'(1)) : a_in;
        mag_b     = b_neg ? (~b_in + word_t'(1)) : b_in;

        rem_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
        trial     = rem_shift - {1'b0, div_reg};
        fits      = !trial[DATA_WIDTH];

        q_fix = q_neg_reg ? (~quo_reg + word_t'(1)) : quo_reg;
        r_fix = r_neg_reg ? (~rem_reg + word_t'(1)) : rem_reg;

        status.last = (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= cnt_t'(DATA_WIDTH - 1);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg   <= mag_a;
            rem_reg   <= '0;
            div_reg   <= mag_b;
            q_neg_reg <= a_neg ^ b_neg;
            r_neg_reg <= a_neg;
            dbz_reg   <= (b_in == '0);
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], fits};
            rem_reg <= fits ? trial[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
        end

        if (cmd.write_out)
        begin
            quotient_reg  <= dbz_reg ? '0 : field_t'(q_fix);
            remainder_reg <= dbz_reg ? '0 : field_t'(r_fix);
            dbz_out_reg   <= dbz_reg;
        end
    end

    assign quotient    = quotient_reg;
    assign remainder   = remainder_reg;
    assign div_by_zero = dbz_out_reg;

endmodule

// ----- rtl/i64div_ctrl.sv -----
// Controller of the divider: sequencing state machine and result handshake.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i64div_ctrl
    import i64div_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output dv_cmd_t    cmd,
    input  dv_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_free       = !rsp_valid_reg || !rsp_stall;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.write_out  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_reg == S_CALC, "accepted word did not start the loop")
    `ASSERT_NEXT(a_last_step_ends, state_reg == S_CALC && status.last, state_reg == S_DONE, "loop did not end after its last step")
    `ASSERT_NEXT(a_result_posted, state_reg == S_DONE && out_free, rsp_valid_reg, "finished result was not posted")

endmodule

// ----- rtl/int64_divider_unit.sv -----
// Top level of the 64-bit signed and unsigned restoring divider.
//
//   Channel   Handshake              Fields
//   req       req_valid, req_stall   req_type, dividend, divisor
//   rsp       rsp_valid, rsp_stall   quotient, remainder, div_by_zero
//
// From acceptance to the next acceptance, one word passes through the load of the operand
// magnitudes, 64 iterations of the shared shift-subtract unit (one quotient bit per
// cycle), and the sign fix into the result register.
// A finished result waits in the result register while the next word is accepted.
// A stalled result holds the divider in its final state until the register frees up.
// Reset clears the controller and the result valid flag; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module int64_divider_unit
    import i64div_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    input  logic   req_type,
    input  field_t dividend,
    input  field_t divisor,
    output logic   rsp_valid,
    input  logic   rsp_stall,
    output field_t quotient,
    output field_t remainder,
    output logic   div_by_zero
);

    dv_cmd_t    cmd;
    dv_status_t status;

    i64div_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    i64div_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req_type),
        .dividend    (dividend),
        .divisor     (divisor),
        .quotient    (quotient),
        .remainder   (remainder),
        .div_by_zero (div_by_zero)
    );

    `ASSERT_NOW(a_dbz_zero, rsp_valid && div_by_zero, quotient == '0 && remainder == '0, "divide by zero result is not zero")

endmodule
